@@ hdl/afr_pkg.sv @@
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types, codes and constants of the audio format resampler.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam int MAX_RUN    = 64;
	localparam int RATE_WIDTH = 16;
	localparam int RUN_W      = $clog2(MAX_RUN + 1);

	typedef enum logic [2:0] {
		FMT_F32 = 3'd0,
		FMT_I32 = 3'd1,
		FMT_I16 = 3'd2,
		FMT_I8  = 3'd3,
		FMT_U8  = 3'd4
	} fmt_code_t;

	typedef enum logic [2:0] {
		REG_SRC_FMT  = 3'd0,
		REG_DST_FMT  = 3'd1,
		REG_GAIN     = 3'd2,
		REG_SRC_RATE = 3'd3,
		REG_DST_RATE = 3'd4
	} reg_index_t;

	localparam logic [31:0] S32_PEAK  = 32'h7FFF_FFFF;
	localparam logic [31:0] S16_PEAK  = 32'h0000_7FFF;
	localparam logic [31:0] S8_PEAK   = 32'h0000_007F;
	localparam logic [31:0] U8_PEAK   = 32'h0000_00FF;
	localparam logic [31:0] GAIN_ONE  = 32'h0100_0000;
	localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
	localparam logic [31:0] Q30_TWO   = 32'h8000_0000;

	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} smag_t;

	// float32 to Q2.30 magnitude, truncated toward zero, saturating
	function automatic smag_t float_to_q30(input logic [31:0] raw);
		logic [7:0]  e;
		logic [23:0] m;
		smag_t       r;
		e     = raw[30:23];
		m     = {1'b1, raw[22:0]};
		r.neg = raw[31];
		if (e == 8'd0) begin
			r.mag = '0;
		end else if (e == 8'd255 && raw[22:0] != '0) begin
			r.mag = '0;
		end else if (e >= 8'd128) begin
			r.mag = raw[31] ? Q30_TWO : Q30_TWO - 32'd1;
		end else if (e >= 8'd120) begin
			r.mag = {8'd0, m} << (e - 8'd120);
		end else if ((8'd120 - e) >= 8'd32) begin
			r.mag = '0;
		end else begin
			r.mag = {8'd0, m} >> (8'd120 - e);
		end
		return r;
	endfunction

endpackage

@@ hdl/audio_format_resampler.sv @@
// ----------------------------------------------------------------------------
// audio_format_resampler
// Sample format converter with nearest-neighbour rate conversion.
// ----------------------------------------------------------------------------
// an accepted item with results runs the 17-step phase divider, then gain
//   on the shared multiplier; integer results are scaled there again and
//   encoded, nonzero float results go through the bit-serial normaliser;
//   the input stalls until the last result of the run is issued, and the run
//   has no gaps while the output does not stall; an item with no results is
//   taken in idle without a stall; reset: arst_n clears sequencer, valid, phase
//   and returns the registers to float32/float32, unity gain, rates of one
module audio_format_resampler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [31:0]                  sample_in,
	input  logic                         buffer_start,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  sample_out,
	output logic                         run_last
);
	import afr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PDIV, S_MGAIN, S_GCLAMP, S_EMUL, S_ENC, S_FNORM, S_EMIT
	} state_t;

	state_t                 state_q;
	logic [2:0]             src_fmt_q, dst_fmt_q;
	logic [31:0]            gain_q;
	logic [RATE_WIDTH-1:0]  src_rate_q, dst_rate_q;
	logic [RATE_WIDTH:0]    phase_q;
	logic [31:0]            raw_q;
	logic [RATE_WIDTH:0]    dvd_q;
	logic [31:0]            rem_q;
	logic [31:0]            dvs_q;
	logic [5:0]             cnt_q;
	logic [31:0]            mag_q;
	logic                   neg_q;
	logic [63:0]            prod_q;
	logic [31:0]            res_q;
	logic [RUN_W-1:0]       left_q;
	logic                   vld_q, last_q;
	logic [31:0]            dout_q;

	// rates with zero read as one
	logic [RATE_WIDTH-1:0]  src_r, dst_r;
	logic                   fmt_ok, accept;
	logic [RATE_WIDTH:0]    acc;
	logic [32:0]            trial;
	logic                   ge;
	logic [31:0]            rem_nx;
	logic [RATE_WIDTH:0]    dvd_nx;
	logic [31:0]            enc_max, mul_b;
	logic [63:0]            mul_p;
	logic [RATE_WIDTH+1:0]  run_n;
	logic [RATE_WIDTH:0]    new_phase;
	smag_t                  fsrc;
	logic [31:0]            ival;
	logic                   isign;
	logic [31:0]            iabs;
	logic [7:0]             u8d;
	logic [31:0]            ihalf;
	logic [9:0]             i8x4;
	logic [31:0]            inorm;
	logic [33:0]            ienc_v;
	logic [39:0]            up;
	logic [39:0]            ut;
	logic [31:0]            enc_res;
	logic [31:0]            gmag;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = vld_q;
	assign sample_out = dout_q;
	assign run_last  = last_q;

	assign src_r  = (src_rate_q == '0) ? RATE_WIDTH'(1) : src_rate_q;
	assign dst_r  = (dst_rate_q == '0) ? RATE_WIDTH'(1) : dst_rate_q;
	assign fmt_ok = (src_fmt_q <= FMT_U8) && (dst_fmt_q <= FMT_U8) &&
	                (src_fmt_q == FMT_F32 || dst_fmt_q == FMT_F32);
	assign acc    = buffer_start ? '0 : phase_q;

	// restoring divider step
	assign trial  = {rem_q, dvd_q[RATE_WIDTH]};
	assign ge     = trial >= {1'b0, dvs_q};
	assign rem_nx = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
	assign dvd_nx = {dvd_q[RATE_WIDTH-1:0], ge};

	assign run_n     = {1'b0, dvd_nx} + (RATE_WIDTH+2)'(1);
	assign new_phase = {1'b0, src_r} - (RATE_WIDTH+1)'(1) - {1'b0, rem_nx[RATE_WIDTH-1:0]};

	// source normalization operands
	assign fsrc = float_to_q30(raw_q);
	always_comb begin
		u8d = raw_q[7:0] - 8'd128;
		case (src_fmt_q)
			FMT_I16: ival = {{16{raw_q[15]}}, raw_q[15:0]};
			FMT_I8:  ival = {{24{raw_q[7]}}, raw_q[7:0]};
			FMT_U8:  ival = {{24{u8d[7]}}, u8d};
			default: ival = raw_q;
		endcase
		isign = ival[31];
		iabs  = isign ? 32'(0 - ival) : ival;
	end

	// magnitude times 2^30 over full scale: full scale is one less than a power
	// of two, so the quotient is a sum of shifted copies, plus a small compare but for u8
	always_comb begin
		ihalf = {1'b0, iabs[31:1]};
		i8x4  = {iabs[7:0], 2'b00};
		case (src_fmt_q)
			FMT_I16: inorm = {iabs[16:0], 15'd0} + iabs + 32'(iabs >= S16_PEAK);
			FMT_I8:  inorm = {iabs[8:0], 23'd0} + {iabs[15:0], 16'd0} +
			                 {iabs[22:0], 9'd0} + {iabs[29:0], 2'd0} +
			                 32'(i8x4 >= 10'd127) + 32'(i8x4 >= 10'd254) +
			                 32'(i8x4 >= 10'd381) + 32'(i8x4 >= 10'd508);
			FMT_U8:  inorm = {iabs[8:0], 23'd0} + {iabs[16:0], 15'd0} +
			                 {iabs[24:0], 7'd0} + ihalf;
			default: inorm = ihalf + 32'(({1'b0, ihalf} + {2'b0, iabs[0], 30'd0}) >=
			                             {1'b0, S32_PEAK});
		endcase
	end

	always_comb begin
		case (dst_fmt_q)
			FMT_I32: enc_max = S32_PEAK;
			FMT_I16: enc_max = S16_PEAK;
			FMT_I8:  enc_max = S8_PEAK;
			default: enc_max = U8_PEAK;
		endcase
	end

	// one multiplier, shared by gain and destination scaling
	assign mul_b = (state_q == S_MGAIN) ? gain_q : enc_max;
	assign mul_p = {32'd0, mag_q} * {32'd0, mul_b};

	assign gmag = (prod_q[63:24] > {8'd0, Q30_TWO}) ? Q30_TWO : prod_q[55:24];

	always_comb begin
		ienc_v = prod_q[63:30];
		up     = prod_q[39:0];
		ut     = '0;
		if (dst_fmt_q == FMT_U8) begin
			if (neg_q) begin
				if (up > 40'h40_0000_0000) begin
					enc_res = '0;
				end else begin
					ut      = (40'h40_0000_0000 - up) >> 31;
					enc_res = {24'd0, ut[7:0]};
				end
			end else begin
				ut      = (40'h40_0000_0000 + up) >> 31;
				enc_res = (ut > 40'd255) ? U8_PEAK : {24'd0, ut[7:0]};
			end
		end else begin
			if (neg_q) begin
				if (ienc_v > {2'b0, enc_max} + 34'd1) begin
					ienc_v = {2'b0, enc_max} + 34'd1;
				end
				enc_res = 32'(0 - ienc_v[31:0]);
			end else begin
				if (ienc_v > {2'b0, enc_max}) begin
					ienc_v = {2'b0, enc_max};
				end
				enc_res = ienc_v[31:0];
			end
			case (dst_fmt_q)
				FMT_I16: enc_res = {16'd0, enc_res[15:0]};
				FMT_I8:  enc_res = {24'd0, enc_res[7:0]};
				default: enc_res = enc_res;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			src_fmt_q  <= FMT_F32;
			dst_fmt_q  <= FMT_F32;
			gain_q     <= GAIN_ONE;
			src_rate_q <= RATE_WIDTH'(1);
			dst_rate_q <= RATE_WIDTH'(1);
			phase_q    <= '0;
			vld_q      <= 1'b0;
			left_q     <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SRC_FMT:  src_fmt_q  <= cfg_data[2:0];
					REG_DST_FMT:  dst_fmt_q  <= cfg_data[2:0];
					REG_GAIN:     gain_q     <= cfg_data;
					REG_SRC_RATE: src_rate_q <= cfg_data[RATE_WIDTH-1:0];
					REG_DST_RATE: dst_rate_q <= cfg_data[RATE_WIDTH-1:0];
					default: ;
				endcase
			end
			if (vld_q && !out_stall && state_q != S_EMIT) begin
				vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						raw_q <= sample_in;
						if (!fmt_ok) begin
							phase_q <= acc;
						end else if (acc >= {1'b0, dst_r}) begin
							phase_q <= acc - {1'b0, dst_r};
						end else begin
							dvd_q   <= {1'b0,
							            RATE_WIDTH'({1'b0, dst_r} - acc - (RATE_WIDTH+1)'(1))};
							rem_q   <= '0;
							dvs_q   <= {(32-RATE_WIDTH)'(0), src_r};
							cnt_q   <= 6'(RATE_WIDTH + 1);
							state_q <= S_PDIV;
						end
					end
				end
				S_PDIV: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						phase_q <= new_phase;
						left_q  <= (run_n > (RATE_WIDTH+2)'(MAX_RUN)) ?
						           RUN_W'(MAX_RUN) : RUN_W'(run_n);
						rem_q   <= '0;
						state_q <= S_MGAIN;
						if (src_fmt_q == FMT_F32) begin
							mag_q <= fsrc.mag;
							neg_q <= fsrc.neg;
						end else begin
							mag_q <= inorm;
							neg_q <= isign;
						end
					end
				end
				S_MGAIN: begin
					prod_q  <= mul_p;
					state_q <= S_GCLAMP;
				end
				S_GCLAMP: begin
					if (dst_fmt_q == FMT_F32) begin
						cnt_q <= '0;
						if (gmag == '0) begin
							res_q   <= '0;
							state_q <= S_EMIT;
						end else begin
							mag_q   <= (gmag > Q30_ONE) ? Q30_ONE : gmag;
							state_q <= S_FNORM;
						end
					end else begin
						mag_q   <= gmag;
						state_q <= S_EMUL;
					end
				end
				S_EMUL: begin
					prod_q  <= mul_p;
					state_q <= S_ENC;
				end
				S_ENC: begin
					res_q   <= enc_res;
					state_q <= S_EMIT;
				end
				S_FNORM: begin
					// shift left until the leading one reaches bit 30
					if (mag_q[30]) begin
						res_q   <= {neg_q, 8'(8'd127 - {2'd0, cnt_q}), mag_q[29:7]};
						state_q <= S_EMIT;
					end else begin
						mag_q <= {mag_q[30:0], 1'b0};
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_EMIT: begin
					if (!vld_q || !out_stall) begin
						vld_q  <= 1'b1;
						dout_q <= res_q;
						last_q <= (left_q == RUN_W'(1));
						left_q <= left_q - RUN_W'(1);
						if (left_q == RUN_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/afr_checker.sv @@
// ----------------------------------------------------------------------------
// afr_checker
// Port-level checks for the audio format resampler.
// ----------------------------------------------------------------------------
module afr_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] sample_out,
	input logic        run_last
);
	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(run_last))
		else $error("result changed while stalled");

	// results only start while an item is in work
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in work");

	// a run continues without gaps until its last result
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("gap inside a run");

	// an unfinished run keeps the input stalled
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> in_stall)
		else $error("input open during a run");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind audio_format_resampler afr_port_checks u_afr_port_checks (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_ready  (cfg_ready),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out),
	.run_last   (run_last)
);

@@ bench/afr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afr_checker
// Watches the register, input and output channels of the audio format
// resampler, predicts every result from its own copy of the registers and
// phase accumulator, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module afr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] sample_in,
	input  logic        buffer_start,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] sample_out,
	input  logic        run_last,
	output int          failures,
	output int          awaited
);
	import afr_pkg::*;

	typedef struct {
		logic [31:0] sample;
		logic        last;
	} run_sample_t;

	run_sample_t awaited_samples[$];

	logic [2:0]  src_fmt;
	logic [2:0]  dst_fmt;
	logic [31:0] gain_q24;
	logic [15:0] src_rate;
	logic [15:0] dst_rate;
	logic [16:0] phase;

	// signed Q2.30 from raw source bits
	function automatic longint normalise(input logic [31:0] raw, input logic [2:0] fmt);
		int unsigned ex;
		longint      mant;
		longint      m;
		ex   = raw[30:23];
		mant = {40'd0, 1'b1, raw[22:0]};
		case (fmt)
			FMT_F32: begin
				if (ex == 0) return 0;
				if (ex == 255 && raw[22:0] != 0) return 0;
				if (ex >= 128) return raw[31] ? -(64'sd1 <<< 31) : (64'sd1 <<< 31) - 1;
				if (ex >= 120) m = mant <<< (ex - 120);
				else if (120 - ex >= 32) m = 0;
				else m = mant >>> (120 - ex);
				return raw[31] ? -m : m;
			end
			FMT_I32: return (longint'($signed(raw)) * (64'sd1 <<< 30)) / 64'sd2147483647;
			FMT_I16: return (longint'($signed(raw[15:0])) * (64'sd1 <<< 30)) / 64'sd32767;
			FMT_I8:  return (longint'($signed(raw[7:0])) * (64'sd1 <<< 30)) / 64'sd127;
			default: return ((longint'(raw[7:0]) - 128) * (64'sd1 <<< 31)) / 64'sd255;
		endcase
	endfunction

	function automatic logic [31:0] to_integer(input logic [63:0] mag, input logic neg,
	                                          input logic [63:0] maxv, input logic [31:0] mask);
		logic [63:0] v;
		v = (mag * maxv) >> 30;
		if (neg) begin
			if (v > maxv + 1) v = maxv + 1;
			v = 64'd0 - v;
		end else if (v > maxv) begin
			v = maxv;
		end
		return v[31:0] & mask;
	endfunction

	function automatic logic [31:0] to_float(input logic [63:0] mag, input logic neg);
		int unsigned p;
		logic [63:0] mant;
		if (mag > 64'd1 << 30) mag = 64'd1 << 30;
		if (mag == 0) return 32'd0;
		p = 0;
		while (p < 30 && (mag >> (p + 1)) != 0) p++;
		mant = (p > 23) ? mag >> (p - 23) : mag << (23 - p);
		return {neg, 8'(p + 97), mant[22:0]};
	endfunction

	function automatic logic [31:0] convert_sample(input logic [31:0] raw);
		longint      x;
		longint      total;
		logic        neg;
		logic [63:0] mag;
		x   = normalise(raw, src_fmt);
		neg = x < 0;
		mag = neg ? 64'(-x) : 64'(x);
		mag = (mag * {32'd0, gain_q24}) >> 24;
		if (mag > 64'd1 << 31) mag = 64'd1 << 31;
		case (dst_fmt)
			FMT_I32: return to_integer(mag, neg, 64'(S32_PEAK), 32'hFFFF_FFFF);
			FMT_I16: return to_integer(mag, neg, 64'(S16_PEAK), 32'h0000_FFFF);
			FMT_I8:  return to_integer(mag, neg, 64'(S8_PEAK), 32'h0000_00FF);
			FMT_U8: begin
				total = (64'sd128 <<< 31) + (neg ? -longint'(mag) : longint'(mag)) * 255;
				if (total < 0) return 32'd0;
				total = total >>> 31;
				return (total > 255) ? 32'd255 : 32'(total);
			end
			default: return to_float(mag, neg);
		endcase
	endfunction

	task automatic predict_run(input logic [31:0] raw, input logic start);
		int unsigned src, dst, acc, n, emit;
		logic [31:0] value;
		n = 0;
		if (start) phase = '0;
		if (src_fmt > 4 || dst_fmt > 4 || (src_fmt != FMT_F32 && dst_fmt != FMT_F32)) return;
		src = (src_rate == 0) ? 1 : src_rate;
		dst = (dst_rate == 0) ? 1 : dst_rate;
		acc = phase;
		if (acc < dst) begin
			n = (dst - acc + src - 1) / src;
			acc += n * src;
		end
		phase = 17'(acc - dst);
		emit  = (n > MAX_RUN) ? MAX_RUN : n;
		if (emit == 0) return;
		value = convert_sample(raw);
		for (int k = 0; k < emit; k++)
			awaited_samples.push_back('{value, k + 1 == emit});
	endtask

	always @(posedge clk or negedge arst_n) begin
		run_sample_t want;
		if (!arst_n) begin
			src_fmt  <= FMT_F32;
			dst_fmt  <= FMT_F32;
			gain_q24 <= GAIN_ONE;
			src_rate <= 16'd1;
			dst_rate <= 16'd1;
			phase    = '0;
			failures = 0;
			awaited_samples.delete();
			awaited  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SRC_FMT:  src_fmt  <= cfg_data[2:0];
					REG_DST_FMT:  dst_fmt  <= cfg_data[2:0];
					REG_GAIN:     gain_q24 <= cfg_data;
					REG_SRC_RATE: src_rate <= cfg_data[15:0];
					REG_DST_RATE: dst_rate <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_run(sample_in, buffer_start);
			if (out_valid && !out_stall) begin
				if (awaited_samples.size() == 0) begin
					$display("%0t: unexpected result sample_out=%h run_last=%b",
						$time, sample_out, run_last);
					failures++;
				end else begin
					want = awaited_samples.pop_front();
					if (sample_out !== want.sample) begin
						$display("%0t: sample_out expected %h actual %h",
							$time, want.sample, sample_out);
						failures++;
					end
					if (run_last !== want.last) begin
						$display("%0t: run_last expected %b actual %b",
							$time, want.last, run_last);
						failures++;
					end
				end
			end
			awaited = awaited_samples.size();
		end
	end

endmodule

@@ bench/tb_audio_format_resampler.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_audio_format_resampler
// Drives the resampler through a sequence of format, gain and rate settings
// with directed extremes and random samples under random idling on both
// sides; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_audio_format_resampler;
	import afr_pkg::*;

	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         SETTLE      = 250;
	localparam logic [2:0] NO_SUCH_REG = 3'd6;
	localparam logic [2:0] BAD_FMT     = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] sample_in = '0;
	logic        buffer_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] sample_out;
	logic        run_last;
	int          failures;
	int          awaited;
	int          cycles = 0;
	logic        calm = 1'b0;
	logic [2:0]  cur_src;

	always #6 clk = ~clk;

	audio_format_resampler dut (.*);

	afr_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(input logic [2:0] sf, input logic [2:0] df, input logic [31:0] g,
	                        input logic [15:0] sr, input logic [15:0] dr);
		drain();
		write_reg(REG_SRC_FMT, {29'd0, sf});
		write_reg(REG_DST_FMT, {29'd0, df});
		write_reg(REG_GAIN, g);
		write_reg(REG_SRC_RATE, {16'd0, sr});
		write_reg(REG_DST_RATE, {16'd0, dr});
		cur_src = sf;
	endtask

	// called at a clock edge; valid stays high across back-to-back items
	task automatic send(input logic [31:0] data, input logic start);
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_in    <= data;
		buffer_start <= start;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [31:0] pick_sample(input logic [2:0] fmt);
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0: return r;
			1: return {r[31], 8'(8'd255 * r[0]), r[22:0]};
			2: return r & 32'h8000_00FF;
			default:
				if (fmt == FMT_F32)
					return {r[31], 8'($urandom_range(140, 95)), r[22:0]};
				else
					return r;
		endcase
	endfunction

	task automatic random_items(input int count);
		repeat (count) send(pick_sample(cur_src), $urandom_range(9) == 0);
	endtask

	initial begin
		logic [31:0] edges[10];
		logic [31:0] gains[4];
		edges = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF,
		          32'h0000_8000, 32'h0000_007F, 32'h0000_0080, 32'h0000_00FF, 32'hFFFF_FF00};
		gains = '{32'h0000_0000, GAIN_ONE, 32'hFFFF_FFFF, 32'h0080_0000};
		cur_src = FMT_F32;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// float to float at reset settings: zero, denormal, nan, infinities, saturation
		send(32'h0000_0000, 1'b1);
		send(32'h0000_0001, 1'b0);
		send(32'h7FC0_0001, 1'b0);
		send(32'h7F80_0000, 1'b0);
		send(32'hFF80_0000, 1'b0);
		send(32'h3F80_0000, 1'b0);
		send(32'hBF80_0000, 1'b0);
		send(32'h4020_0000, 1'b0);
		send(32'h3000_0000, 1'b0);
		send(32'h8000_0000, 1'b0);
		send(32'hFFFF_FFFF, 1'b1);

		// zero source rate behaves as one; register beyond the list is ignored
		set_mode(FMT_I32, FMT_F32, 32'hFFFF_FFFF, 16'd0, 16'd1);
		write_reg(NO_SUCH_REG, 32'hFFFF_FFFF);
		foreach (edges[i]) send(edges[i], 1'b0);
		set_mode(FMT_I16, FMT_F32, 32'h0000_0000, 16'd1, 16'd0);
		foreach (edges[i]) if (i < 6) send(edges[i], 1'b0);

		// runs longer than the cap, then heavy dropping
		set_mode(FMT_F32, FMT_F32, GAIN_ONE, 16'd1, 16'd100);
		send(32'h3F00_0000, 1'b1);
		send(32'hBE80_0000, 1'b0);
		set_mode(FMT_F32, FMT_I8, GAIN_ONE, 16'd1, 16'hFFFF);
		send(32'h3F80_0000, 1'b1);
		set_mode(FMT_F32, FMT_U8, GAIN_ONE, 16'hFFFF, 16'd1);
		random_items(6);

		// invalid pairs give nothing but still see buffer starts
		set_mode(FMT_I16, FMT_I8, GAIN_ONE, 16'd1, 16'd1);
		send(32'h1234_5678, 1'b1);
		send(32'h0000_0000, 1'b0);
		set_mode(BAD_FMT, FMT_F32, GAIN_ONE, 16'd1, 16'd1);
		send(32'h3F80_0000, 1'b0);
		set_mode(FMT_F32, BAD_FMT, GAIN_ONE, 16'd1, 16'd1);
		send(32'h3F80_0000, 1'b1);

		set_mode(FMT_F32, FMT_I32, GAIN_ONE, 16'd3, 16'd7);
		calm = 1'b1;
		random_items(30);
		calm = 1'b0;
		set_mode(FMT_F32, FMT_I16, 32'h0200_0000, 16'd7, 16'd3);
		random_items(25);
		set_mode(FMT_I8, FMT_F32, 32'h0180_0000, 16'd2, 16'd5);
		random_items(25);
		set_mode(FMT_U8, FMT_F32, GAIN_ONE, 16'd1, 16'd2);
		random_items(25);
		set_mode(FMT_F32, FMT_U8, 32'h0080_0000, 16'd1, 16'd1);
		random_items(25);
		set_mode(FMT_F32, FMT_I8, GAIN_ONE, 16'hFFFF, 16'hFFFF);
		random_items(20);

		// random settings, rates from 1 to 8
		repeat (8) begin
			logic [2:0] a;
			logic [2:0] b;
			a = $urandom_range(4);
			b = $urandom_range(4);
			if ($urandom_range(1)) a = FMT_F32; else b = FMT_F32;
			set_mode(a, b, ($urandom_range(1) ? gains[$urandom_range(3)] : $urandom),
				16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)));
			random_items(12);
		end

		drain();
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
